### hw/rtl/checksummed_frame_receiver_defines.svh
// Assertion macros shared by the frame receiver RTL files.
// No dependencies; modules take this in with a plain include.
`ifndef CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH
`define CHECKSUMMED_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked while out of reset
`define CFR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Property checked at every edge, reset included
`define CFR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CFR_ASSERT(lbl, prop, msg)
`define CFR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### hw/rtl/cfr_pkg.sv
// Shared types and constants for the checksummed frame receiver.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cfr_pkg;

  // Frame format
  localparam logic [7:0] HDR1       = 8'hAA;
  localparam logic [7:0] HDR2       = 8'hAF;
  localparam logic [7:0] FUNC_LIMIT = 8'hF1;
  localparam int         MAX_LEN    = 50;

  // Function codes
  localparam logic [7:0] FN_FRONT = 8'h01;
  localparam logic [7:0] FN_BACK  = 8'h02;
  localparam logic [7:0] FN_CTRL  = 8'h03;
  localparam logic [7:0] FN_READY = 8'h04;

  // Camera ids in a ready frame
  localparam logic [7:0] CAM1 = 8'h01;
  localparam logic [7:0] CAM2 = 8'h02;

  // Payload counters and head store
  localparam int POS_W      = 6;
  localparam int HEAD_DEPTH = 8;
  localparam int HEAD_IDX_W = $clog2(HEAD_DEPTH);

  localparam logic [POS_W-1:0] NEED_TARGET = POS_W'(4);
  localparam logic [POS_W-1:0] NEED_CTRL   = POS_W'(8);
  localparam logic [POS_W-1:0] NEED_READY  = POS_W'(2);

  // Result kinds
  localparam logic [2:0] KIND_FRONT  = 3'd0;
  localparam logic [2:0] KIND_BACK   = 3'd1;
  localparam logic [2:0] KIND_CTRL   = 3'd2;
  localparam logic [2:0] KIND_READY1 = 3'd3;
  localparam logic [2:0] KIND_READY2 = 3'd4;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_HUNT  = 6'b000001,
    PH_HEAD2 = 6'b000010,
    PH_FUNC  = 6'b000100,
    PH_LEN   = 6'b001000,
    PH_PAY   = 6'b010000,
    PH_SUM   = 6'b100000
  } phase_t;

  // One decoded result
  typedef struct packed {
    logic [2:0]  frame_kind;
    logic [15:0] word_a;
    logic [15:0] word_b;
    logic [15:0] word_c;
    logic [15:0] word_d;
    logic        reply_ready;
  } result_t;

endpackage

`default_nettype wire

### hw/rtl/cfr_parser.sv
// Frame parser: phase machine, running checksum, head payload store and decode.
// Depends on cfr_pkg and checksummed_frame_receiver_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "checksummed_frame_receiver_defines.svh"

module cfr_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            fire_i,
  input  wire logic [7:0]      byte_i,
  output logic                 res_vld_o,
  output cfr_pkg::result_t     res_o
);

  cfr_pkg::phase_t              phase_r, phase_nxt;
  logic [cfr_pkg::POS_W-1:0]    left_r, left_nxt;
  logic [cfr_pkg::POS_W-1:0]    pos_r, pos_nxt;
  logic [7:0]                   sum_r, sum_nxt;
  logic [7:0]                   func_r, func_nxt;
  logic [7:0]                   head_r [cfr_pkg::HEAD_DEPTH];
  logic                         head_we;
  logic                         dec_ok;
  logic                         sum_match;
  cfr_pkg::result_t             dec;

  // Next phase, counters and checksum for the byte in hand
  always_comb begin
    phase_nxt = phase_r;
    left_nxt  = left_r;
    pos_nxt   = pos_r;
    sum_nxt   = sum_r;
    func_nxt  = func_r;
    head_we   = 1'b0;
    unique case (phase_r)
      cfr_pkg::PH_HUNT: begin
        if (byte_i == cfr_pkg::HDR1) begin
          sum_nxt   = byte_i;
          phase_nxt = cfr_pkg::PH_HEAD2;
        end
      end
      cfr_pkg::PH_HEAD2: begin
        if (byte_i == cfr_pkg::HDR2) begin
          sum_nxt   = sum_r + byte_i;
          phase_nxt = cfr_pkg::PH_FUNC;
        end else begin
          phase_nxt = cfr_pkg::PH_HUNT;
        end
      end
      cfr_pkg::PH_FUNC: begin
        if (byte_i < cfr_pkg::FUNC_LIMIT) begin
          func_nxt  = byte_i;
          sum_nxt   = sum_r + byte_i;
          phase_nxt = cfr_pkg::PH_LEN;
        end else begin
          phase_nxt = cfr_pkg::PH_HUNT;
        end
      end
      cfr_pkg::PH_LEN: begin
        if (byte_i != 8'd0 && byte_i < 8'(cfr_pkg::MAX_LEN)) begin
          left_nxt  = byte_i[cfr_pkg::POS_W-1:0];
          pos_nxt   = '0;
          sum_nxt   = sum_r + byte_i;
          phase_nxt = cfr_pkg::PH_PAY;
        end else begin
          phase_nxt = cfr_pkg::PH_HUNT;
        end
      end
      cfr_pkg::PH_PAY: begin
        if (left_r == '0) begin
          phase_nxt = cfr_pkg::PH_HUNT;
        end else begin
          head_we  = (pos_r < cfr_pkg::POS_W'(cfr_pkg::HEAD_DEPTH));
          pos_nxt  = pos_r + cfr_pkg::POS_W'(1);
          sum_nxt  = sum_r + byte_i;
          left_nxt = left_r - cfr_pkg::POS_W'(1);
          if (left_r == cfr_pkg::POS_W'(1)) begin
            phase_nxt = cfr_pkg::PH_SUM;
          end
        end
      end
      cfr_pkg::PH_SUM: begin
        phase_nxt = cfr_pkg::PH_HUNT;
      end
      default: begin
        phase_nxt = cfr_pkg::PH_HUNT;
      end
    endcase
  end

  // Decode the stored head bytes by function code
  always_comb begin
    dec    = '0;
    dec_ok = 1'b0;
    case (func_r) inside
      cfr_pkg::FN_FRONT, cfr_pkg::FN_BACK: begin
        dec_ok         = (pos_r >= cfr_pkg::NEED_TARGET);
        dec.frame_kind = (func_r == cfr_pkg::FN_FRONT) ? cfr_pkg::KIND_FRONT
                                                       : cfr_pkg::KIND_BACK;
        dec.word_a     = {8'h00, head_r[0]};
        dec.word_b     = {8'h00, head_r[1]};
        dec.word_c     = {8'h00, head_r[2]};
        dec.word_d     = {8'h00, head_r[3]};
      end
      cfr_pkg::FN_CTRL: begin
        dec_ok         = (pos_r >= cfr_pkg::NEED_CTRL);
        dec.frame_kind = cfr_pkg::KIND_CTRL;
        dec.word_a     = {head_r[0], head_r[1]};
        dec.word_b     = {head_r[2], head_r[3]};
        dec.word_c     = {head_r[4], head_r[5]};
        dec.word_d     = {head_r[6], head_r[7]};
      end
      cfr_pkg::FN_READY: begin
        dec.word_a = {8'h00, head_r[1]};
        if (head_r[0] == cfr_pkg::CAM1) begin
          dec_ok          = (pos_r >= cfr_pkg::NEED_READY);
          dec.frame_kind  = cfr_pkg::KIND_READY1;
          dec.reply_ready = 1'b1;
        end else if (head_r[0] == cfr_pkg::CAM2) begin
          dec_ok         = (pos_r >= cfr_pkg::NEED_READY);
          dec.frame_kind = cfr_pkg::KIND_READY2;
        end
      end
      default: begin
        dec_ok = 1'b0;
      end
    endcase
  end

  // Emit on a checksum byte that matches a decodable frame
  assign sum_match = (byte_i == sum_r);
  assign res_vld_o = fire_i && (phase_r == cfr_pkg::PH_SUM) && sum_match && dec_ok;
  assign res_o     = dec;

  // Advance parser state on each transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cfr_pkg::PH_HUNT;
      left_r  <= '0;
      pos_r   <= '0;
      sum_r   <= '0;
      func_r  <= '0;
    end else if (fire_i) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      pos_r   <= pos_nxt;
      sum_r   <= sum_nxt;
      func_r  <= func_nxt;
    end
  end

  // Store the first payload bytes
  always_ff @(posedge clk) begin
    if (fire_i && head_we) begin
      head_r[pos_r[cfr_pkg::HEAD_IDX_W-1:0]] <= byte_i;
    end
  end

  `CFR_ASSERT(a_res_only_on_sum, res_vld_o |-> (phase_r == cfr_pkg::PH_SUM), "result outside checksum phase")
  `CFR_ASSERT(a_pay_to_sum_last, (fire_i && phase_r == cfr_pkg::PH_PAY && phase_nxt == cfr_pkg::PH_SUM) |-> (left_r == cfr_pkg::POS_W'(1)), "checksum phase entered early")
  `CFR_ASSERT(a_pos_bounded, pos_r < cfr_pkg::POS_W'(cfr_pkg::MAX_LEN), "payload position past max length")
  `CFR_ASSERT(a_reply_cam1, (res_vld_o && res_o.reply_ready) |-> (res_o.frame_kind == cfr_pkg::KIND_READY1), "reply flag on wrong kind")

endmodule

`default_nettype wire

### hw/rtl/cfr_out_reg.sv
// Result register for the frame receiver output channel.
// Depends on cfr_pkg and checksummed_frame_receiver_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "checksummed_frame_receiver_defines.svh"

module cfr_out_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              load_i,
  input  wire cfr_pkg::result_t  res_i,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output cfr_pkg::result_t       res_o,
  output logic                   slot_free_o
);

  logic             valid_r, valid_nxt;
  cfr_pkg::result_t res_r;

  // Slot can take a new result when empty or draining this cycle
  assign slot_free_o = !valid_r || out_ready_i;

  always_comb begin
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid_o = valid_r;
  assign res_o       = res_r;

  `CFR_ASSERT_ALWAYS(a_reset_clears, $past(!rst_n) |-> !valid_r, "result valid after reset")
  `CFR_ASSERT(a_no_overwrite, (valid_r && !out_ready_i) |-> !load_i, "pending result overwritten")
  `CFR_ASSERT(a_drop_after_transfer, $fell(valid_r) |-> $past(out_ready_i), "result dropped without transfer")

endmodule

`default_nettype wire

### hw/rtl/checksummed_frame_receiver.sv
// Checksummed frame receiver, top level. Depends on cfr_pkg, cfr_parser, cfr_out_reg.
// Takes one serial byte per transfer and hunts for frames of the form 0xAA 0xAF,
// function, length, payload, checksum (8-bit sum of all earlier frame bytes).
// A good frame with function 1..4 that carries enough payload yields one result;
// every other byte yields none. A byte can be accepted every clock cycle while
// in_ready is high. Each byte waits in the input byte register and is parsed once
// the result register has room; a result is loaded there and drives out_valid.
// in_ready stays high while the result register is empty or being drained, and
// drops only when a result waits and the input register is occupied.
`timescale 1ns / 1ps
`default_nettype none

module checksummed_frame_receiver (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_frame_kind,
  output logic [15:0]      out_word_a,
  output logic [15:0]      out_word_b,
  output logic [15:0]      out_word_c,
  output logic [15:0]      out_word_d,
  output logic             out_reply_ready
);

  logic             byte_vld_r, byte_vld_nxt;
  logic [7:0]       byte_r;
  logic             slot_free;
  logic             s1_fire;
  logic             in_xfer;
  logic             res_vld;
  cfr_pkg::result_t res;
  cfr_pkg::result_t out_res;

  // Input byte register
  assign s1_fire  = byte_vld_r && slot_free;
  assign in_ready = !byte_vld_r || slot_free;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    if (in_xfer) begin
      byte_vld_nxt = 1'b1;
    end else if (s1_fire) begin
      byte_vld_nxt = 1'b0;
    end else begin
      byte_vld_nxt = byte_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_vld_r <= 1'b0;
    end else begin
      byte_vld_r <= byte_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      byte_r <= in_rx_byte;
    end
  end

  // Parse and decode
  cfr_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire_i    (s1_fire),
    .byte_i    (byte_r),
    .res_vld_o (res_vld),
    .res_o     (res)
  );

  // Result register
  cfr_out_reg u_out_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (res_vld),
    .res_i       (res),
    .out_ready_i (out_ready),
    .out_valid_o (out_valid),
    .res_o       (out_res),
    .slot_free_o (slot_free)
  );

  assign out_frame_kind  = out_res.frame_kind;
  assign out_word_a      = out_res.word_a;
  assign out_word_b      = out_res.word_b;
  assign out_word_c      = out_res.word_c;
  assign out_word_d      = out_res.word_d;
  assign out_reply_ready = out_res.reply_ready;

endmodule

`default_nettype wire
